@@ rtl/psar_pkg.sv @@
// psar_pkg: shared constants, types and helpers for the partial sum/average reducer.
// No dependencies; imported by psar_ctrl, psar_dp and the top level (psar_ram does not use it).
package psar_pkg;

   localparam int MAX_ELEMENTS = 4096;
   localparam int MAX_PARTIALS = 256;

   localparam int VALUE_W    = 32;                      // Q16.16 sample width
   localparam int ACC_W      = 40;                      // accumulator width
   localparam int NP_W       = 9;                       // num_partials register width
   localparam int NE_W       = 13;                      // num_elements register width
   localparam int IDX_W      = 12;                      // element_index field width
   localparam int ELEM_CNT_W = $clog2(MAX_ELEMENTS);
   localparam int PART_CNT_W = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
   localparam int DIV_CNT_W  = $clog2(ACC_W);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = NE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE         = 2'd0,
      CSR_NUM_PARTIALS = 2'd1,
      CSR_NUM_ELEMENTS = 2'd2
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;     // input transaction accepted, read accumulator
      logic acc_write;   // accumulate and write back, load divider
      logic div_step;    // one restoring divide step
      logic out_load;    // load output register
   } psar_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_partial;
      logic avg_mode;
      logic div_last;
   } psar_sts_type;

   function automatic logic [ACC_W-1:0] sat_add_acc(input logic [ACC_W-1:0] a,
                                                     input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return s[ACC_W-1:0];
   endfunction

   // Saturate a signed ACC_W+1 bit value to the signed VALUE_W output range
   function automatic logic [VALUE_W-1:0] sat_out(input logic [ACC_W:0] v);
      logic [ACC_W-VALUE_W+1:0] top;
      top = v[ACC_W:VALUE_W-1];
      if ((top == '0) || (top == '1)) begin
         return v[VALUE_W-1:0];
      end
      return v[ACC_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
   endfunction

endpackage

@@ rtl/psar_ram.sv @@
// psar_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module psar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/psar_ctrl.sv @@
// psar_ctrl: sequencing state machine and output valid for the reducer.
// Depends on psar_pkg.
module psar_ctrl
   import psar_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  psar_sts_type sts,
   output psar_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_ACC  = 4'b0010,
      S_DIV  = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc_write = 1'b1;
            priority if (!sts.last_partial) begin
               state_in = S_IDLE;
            end else if (sts.avg_mode) begin
               state_in = S_DIV;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while stalled");

   a_accept_to_acc: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_ACC))
      else $error("accepted transaction not followed by accumulate");

   a_div_only_avg: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> sts.avg_mode)
      else $error("divider stepped in sum mode");

   a_no_result_back_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC && !sts.last_partial) |=> (state_ff == S_IDLE && !cmd.out_load))
      else $error("non-final partial produced a result");

endmodule

@@ rtl/psar_dp.sv @@
// psar_dp: config registers, stream counters, accumulator RAM, serial divider, output register.
// Depends on psar_pkg and psar_ram.
module psar_dp
   import psar_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic [VALUE_W-1:0]    req_value,
   input  psar_cmd_type          cmd,
   output psar_sts_type          sts,
   output logic [VALUE_W-1:0]    rsp_result,
   output logic [IDX_W-1:0]      rsp_element_index,
   output logic                  rsp_last
);

   // configuration
   logic            mode_ff;
   logic [NP_W-1:0] num_partials_ff;
   logic [NE_W-1:0] num_elements_ff;
   logic [NP_W-1:0] np_eff;
   logic [NE_W-1:0] ne_eff;

   // stream position
   logic [ELEM_CNT_W-1:0] elem_cnt_ff, elem_cnt_in;
   logic [PART_CNT_W-1:0] part_cnt_ff, part_cnt_in;
   logic                  last_part_now, last_elem_now;

   // captured transaction
   logic [VALUE_W-1:0]    value_ff;
   logic [ELEM_CNT_W-1:0] idx_ff;
   logic                  first_ff, last_part_ff, last_elem_ff;

   // accumulate
   logic [ACC_W-1:0] rd_acc, sum, value_ext, acc_ff;

   // divider
   logic [ACC_W-1:0]     quot_ff, quot_in, sum_mag;
   logic [NP_W-1:0]      rem_ff, rem_in;
   logic [NP_W:0]        rem_shift;
   logic                 neg_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [ACC_W:0]       avg_signed, out_wide;

   // output
   logic [VALUE_W-1:0] rsp_result_ff;
   logic [IDX_W-1:0]   rsp_index_ff;
   logic               rsp_last_ff;

   always_comb begin
      priority if (num_partials_ff == '0) begin
         np_eff = NP_W'(1);
      end else if (32'(num_partials_ff) > MAX_PARTIALS) begin
         np_eff = NP_W'(MAX_PARTIALS);
      end else begin
         np_eff = num_partials_ff;
      end
      priority if (num_elements_ff == '0) begin
         ne_eff = NE_W'(1);
      end else if (32'(num_elements_ff) > MAX_ELEMENTS) begin
         ne_eff = NE_W'(MAX_ELEMENTS);
      end else begin
         ne_eff = num_elements_ff;
      end
   end

   assign last_part_now = (32'(part_cnt_ff) + 32'd1) >= 32'(np_eff);
   assign last_elem_now = (32'(elem_cnt_ff) + 32'd1) >= 32'(ne_eff);

   always_comb begin
      elem_cnt_in = elem_cnt_ff;
      part_cnt_in = part_cnt_ff;
      if (cmd.capture) begin
         if (last_elem_now) begin
            elem_cnt_in = '0;
            part_cnt_in = last_part_now ? '0 : part_cnt_ff + PART_CNT_W'(1);
         end else begin
            elem_cnt_in = elem_cnt_ff + ELEM_CNT_W'(1);
         end
      end
   end

   // config writes restart the stream
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= 1'b0;
         num_partials_ff <= NP_W'(1);
         num_elements_ff <= NE_W'(1);
         elem_cnt_ff     <= '0;
         part_cnt_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE: begin
               mode_ff     <= csr_wr_data[0];
               elem_cnt_ff <= '0;
               part_cnt_ff <= '0;
            end
            CSR_NUM_PARTIALS: begin
               num_partials_ff <= csr_wr_data[NP_W-1:0];
               elem_cnt_ff     <= '0;
               part_cnt_ff     <= '0;
            end
            CSR_NUM_ELEMENTS: begin
               num_elements_ff <= csr_wr_data[NE_W-1:0];
               elem_cnt_ff     <= '0;
               part_cnt_ff     <= '0;
            end
            default: begin
            end
         endcase
      end else begin
         elem_cnt_ff <= elem_cnt_in;
         part_cnt_ff <= part_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         value_ff     <= req_value;
         idx_ff       <= elem_cnt_ff;
         first_ff     <= (part_cnt_ff == '0);
         last_part_ff <= last_part_now;
         last_elem_ff <= last_elem_now;
      end
   end

   psar_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (cmd.acc_write),
      .wr_addr (idx_ff),
      .wr_data (sum),
      .rd_en   (cmd.capture),
      .rd_addr (elem_cnt_ff),
      .rd_data (rd_acc)
   );

   assign value_ext = {{(ACC_W-VALUE_W){value_ff[VALUE_W-1]}}, value_ff};
   assign sum       = first_ff ? value_ext : sat_add_acc(rd_acc, value_ext);
   assign sum_mag   = sum[ACC_W-1] ? (~sum + ACC_W'(1)) : sum;

   // restoring divide, one quotient bit per step, MSB first
   assign rem_shift = {rem_ff, quot_ff[ACC_W-1]};

   always_comb begin
      quot_in = {quot_ff[ACC_W-2:0], 1'b0};
      rem_in  = rem_shift[NP_W-1:0];
      if (rem_shift >= {1'b0, np_eff}) begin
         rem_in     = NP_W'(rem_shift - {1'b0, np_eff});
         quot_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_write) begin
         acc_ff     <= sum;
         quot_ff    <= sum_mag;
         rem_ff     <= '0;
         neg_ff     <= sum[ACC_W-1];
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quot_ff    <= quot_in;
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   assign avg_signed = neg_ff ? (~{1'b0, quot_ff} + (ACC_W+1)'(1)) : {1'b0, quot_ff};
   assign out_wide   = mode_ff ? avg_signed : {acc_ff[ACC_W-1], acc_ff};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_result_ff <= sat_out(out_wide);
         rsp_index_ff  <= IDX_W'(idx_ff);
         rsp_last_ff   <= last_elem_ff;
      end
   end

   assign rsp_result        = rsp_result_ff;
   assign rsp_element_index = rsp_index_ff;
   assign rsp_last          = rsp_last_ff;

   assign sts.last_partial = last_part_ff;
   assign sts.avg_mode     = mode_ff;
   assign sts.div_last     = (div_cnt_ff == DIV_CNT_W'(ACC_W - 1));

endmodule

@@ rtl/partial_sum_average_reducer.sv @@
// partial_sum_average_reducer: top level, joins controller and datapath.
// Depends on psar_pkg, psar_ctrl, psar_dp (and psar_ram through psar_dp).
//
// Reduces num_partials partial tensors of num_elements Q16.16 values each,
// streamed partial-major, into one tensor. Each element has a 40-bit
// accumulator in a 4096-deep RAM: partial 0 writes it, later partials add to
// it with 40-bit saturation. Each element of the last partial yields one
// response transaction: the sum saturated to 32 bits (mode 0) or the sum
// divided by the partial count, truncated toward zero (mode 1), with its
// element index and a last flag on the final element. A count register of
// zero acts as one; counts above 256 partials or 4096 elements are clamped.
// Any csr write restarts the stream at partial 0, element 0; write csrs only
// while the block is idle. One transaction is processed at a time: an element
// that yields no response is accepted, then its accumulator is read from the
// registered RAM, added to and written back; a sum response then loads the
// output register; an average first passes a bit-serial divider resolving
// one of 40 bits per cycle. A finished response waits in the output register,
// and the next request transaction is accepted meanwhile; the pipeline
// only holds where it would need to load a still-stalled output register.
module partial_sum_average_reducer
   import psar_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_W-1:0]    req_value,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_W-1:0]    rsp_result,
   output logic [IDX_W-1:0]      rsp_element_index,
   output logic                  rsp_last
);

   psar_cmd_type cmd;
   psar_sts_type sts;

   psar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   psar_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_value         (req_value),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_result        (rsp_result),
      .rsp_element_index (rsp_element_index),
      .rsp_last          (rsp_last)
   );

endmodule
